// ----- src/sbd_pkg.sv -----
package sbd_pkg;

    localparam int FRAME_BYTES  = 25;
    localparam int CALIB_FRAMES = 10;

    localparam int POS_W  = 5;
    localparam int CH_W   = 11;
    localparam int DW     = 22;   // datapath width, holds gain * (t + u)
    localparam int SPD_W  = 17;
    localparam int LIM_W  = 16;
    localparam int GAIN_W = 8;

    // first and last stored frame bytes (channels 2, 3 and 5 live in bytes 3..9)
    localparam logic [POS_W-1:0] FB_FIRST = POS_W'(3);
    localparam logic [POS_W-1:0] FB_LAST  = POS_W'(9);
    localparam int               FB_DEPTH = 7;

    localparam logic [7:0] SBUS_HEADER = 8'h0F;
    localparam logic [7:0] SBUS_FOOTER = 8'h00;
    localparam logic [3:0] SBUS_FOOT_NIB = 4'h4;

    localparam logic [CH_W-1:0] CH5_LOW  = CH_W'(1800);
    localparam logic [CH_W-1:0] CH5_MID  = CH_W'(1000);
    localparam logic [CH_W-1:0] CH5_HIGH = CH_W'(200);

    localparam logic [1:0] GEAR_LOW  = 2'd0;
    localparam logic [1:0] GEAR_MID  = 2'd1;
    localparam logic [1:0] GEAR_HIGH = 2'd2;

    localparam int         DEADBAND  = 15;
    localparam logic [9:0] TURN_NUM  = 10'd682;
    localparam int         TURN_SHIFT = 10;

    localparam logic [1:0] REG_DRIVE_GAIN = 2'd0;
    localparam logic [1:0] REG_LIMIT_LOW  = 2'd1;
    localparam logic [1:0] REG_LIMIT_MID  = 2'd2;
    localparam logic [1:0] REG_LIMIT_HIGH = 2'd3;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_RCP
    } t_alu_op;

endpackage

// ----- src/sbus_to_differential_drive.sv -----
// The last byte of a valid frame starts a sequence on the shared ALU: the mixing
// path runs DT, DR, TBIAS, UMUL, TGAIN, UGAIN, LEFT, RIGHT, PUSH; a calibration
// frame CSUM_T, CSUM_U, PUSH; the frame that completes calibration adds TBASE and
// UBASE (two reciprocal multiplies). PUSH waits while the previous output is
// untaken. Throughput: 1 byte per cycle outside the sequence, not ready during it.
// Reset: synchronous active-low; clears framing, calibration, gear, config defaults.
module sbus_to_differential_drive #(
    parameter int CALIB_FRAMES = sbd_pkg::CALIB_FRAMES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tuser,   // [0] frame_start
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [16:0] left_speed, [33:17] right_speed, [35:34] gear, [36] calibrated
    output logic [39:0] o_m_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int DW     = sbd_pkg::DW;
    localparam int CH_W   = sbd_pkg::CH_W;
    localparam int POS_W  = sbd_pkg::POS_W;
    localparam int SPD_W  = sbd_pkg::SPD_W;
    localparam int LIM_W  = sbd_pkg::LIM_W;
    localparam int SUM_W  = CH_W + $clog2(CALIB_FRAMES);
    localparam int CNT_W  = $clog2(CALIB_FRAMES + 1);
    // sum / CALIB_FRAMES as (sum * RCP_MUL) >> RCP_SHIFT, exact over the sum range
    localparam int RCP_SHIFT = SUM_W + $clog2(CALIB_FRAMES);
    localparam logic [15:0] RCP_MUL =
        16'(((1 << RCP_SHIFT) + CALIB_FRAMES - 1) / CALIB_FRAMES);
    localparam logic [CNT_W-1:0]  CALIB_N   = CNT_W'(CALIB_FRAMES);
    localparam logic [POS_W-1:0]  POS_LASTB = POS_W'(sbd_pkg::FRAME_BYTES - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CSUM_T,
        S_CSUM_U,
        S_TBASE,
        S_UBASE,
        S_DT,
        S_DR,
        S_TBIAS,
        S_UMUL,
        S_TGAIN,
        S_UGAIN,
        S_LEFT,
        S_RIGHT,
        S_PUSH
    } t_state;

    t_state r_state;

    logic [sbd_pkg::GAIN_W-1:0] r_gain;
    logic [LIM_W-1:0]           r_lim_low;
    logic [LIM_W-1:0]           r_lim_mid;
    logic [LIM_W-1:0]           r_lim_high;

    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_fb [sbd_pkg::FB_DEPTH];
    logic             r_hdr_good;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_tsum;
    logic [SUM_W-1:0] r_usum;
    logic [CH_W-1:0]  r_tbase;
    logic [CH_W-1:0]  r_ubase;
    logic [1:0]       r_gear;

    logic signed [DW-1:0] r_t;
    logic signed [DW-1:0] r_u;
    logic                 r_usign;
    logic signed [DW-1:0] r_l;
    logic signed [DW-1:0] r_r;

    logic        r_m_valid;
    logic [39:0] r_m_data;

    logic [CH_W-1:0] ch2, ch3, ch5;
    logic [1:0]      n_gear;
    logic            in_acc;
    logic            foot_ok;
    logic [2:0]      fb_idx;

    sbd_pkg::t_alu_op     alu_op;
    logic signed [DW-1:0] alu_a, alu_b, alu_y;

    logic                 t_pos;
    logic [LIM_W-1:0]     lim;
    logic signed [DW-1:0] lim_p, lim_n;
    logic signed [DW-1:0] cl_l, cl_r;
    logic signed [11:0]   u_signed;
    logic signed [DW-1:0] t_bias;
    logic signed [DW-1:0] t_shift;

    // r_fb[0] holds frame byte 3
    assign ch2 = {r_fb[2][0], r_fb[1], r_fb[0][7:6]};
    assign ch3 = {r_fb[3][3:0], r_fb[2][7:1]};
    assign ch5 = {r_fb[6][1:0], r_fb[5], r_fb[4][7]};

    assign in_acc  = i_s_tvalid && o_s_tready;
    assign foot_ok = (i_s_tdata == sbd_pkg::SBUS_FOOTER)
                  || (i_s_tdata[3:0] == sbd_pkg::SBUS_FOOT_NIB);
    assign fb_idx  = 3'(r_pos - sbd_pkg::FB_FIRST);

    always_comb begin
        if (ch5 == sbd_pkg::CH5_LOW)       n_gear = sbd_pkg::GEAR_LOW;
        else if (ch5 == sbd_pkg::CH5_MID)  n_gear = sbd_pkg::GEAR_MID;
        else if (ch5 == sbd_pkg::CH5_HIGH) n_gear = sbd_pkg::GEAR_HIGH;
        else                               n_gear = r_gear;
    end

    assign t_pos     = !r_t[DW-1] && (r_t != '0);
    assign u_signed  = r_usign ? -r_u[11:0] : r_u[11:0];

    // truncation toward zero: bias negative values by divisor - 1
    always_comb begin
        case (r_gear)
            sbd_pkg::GEAR_LOW: begin
                t_bias  = r_t[DW-1] ? DW'(3) : '0;
                t_shift = r_t >>> 2;
            end
            sbd_pkg::GEAR_MID: begin
                t_bias  = r_t[DW-1] ? DW'(1) : '0;
                t_shift = r_t >>> 1;
            end
            default: begin
                t_bias  = '0;
                t_shift = r_t;
            end
        endcase
    end

    always_comb begin
        case (r_gear)
            sbd_pkg::GEAR_LOW: lim = r_lim_low;
            sbd_pkg::GEAR_MID: lim = r_lim_mid;
            default:           lim = r_lim_high;
        endcase
    end

    assign lim_p = $signed({{(DW-LIM_W){1'b0}}, lim});
    assign lim_n = -lim_p;
    assign cl_l  = (r_l > lim_p) ? lim_p : (r_l < lim_n) ? lim_n : r_l;
    assign cl_r  = (r_r > lim_p) ? lim_p : (r_r < lim_n) ? lim_n : r_r;

    // operand select for the shared ALU
    always_comb begin
        alu_op = sbd_pkg::ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        case (r_state)
            S_CSUM_T: begin
                alu_a = $signed({{(DW-SUM_W){1'b0}}, r_tsum});
                alu_b = $signed({{(DW-CH_W){1'b0}}, ch2});
            end
            S_CSUM_U: begin
                alu_a = $signed({{(DW-SUM_W){1'b0}}, r_usum});
                alu_b = $signed({{(DW-CH_W){1'b0}}, ch3});
            end
            S_TBASE: begin
                alu_op = sbd_pkg::ALU_RCP;
                alu_a  = $signed({{(DW-SUM_W){1'b0}}, r_tsum});
                alu_b  = $signed({{(DW-16){1'b0}}, RCP_MUL});
            end
            S_UBASE: begin
                alu_op = sbd_pkg::ALU_RCP;
                alu_a  = $signed({{(DW-SUM_W){1'b0}}, r_usum});
                alu_b  = $signed({{(DW-16){1'b0}}, RCP_MUL});
            end
            S_DT: begin
                alu_op = sbd_pkg::ALU_SUB;
                alu_a  = $signed({{(DW-CH_W){1'b0}}, ch2});
                alu_b  = $signed({{(DW-CH_W){1'b0}}, r_tbase});
            end
            S_DR: begin
                alu_op = sbd_pkg::ALU_SUB;
                alu_a  = $signed({{(DW-CH_W){1'b0}}, ch3});
                alu_b  = $signed({{(DW-CH_W){1'b0}}, r_ubase});
            end
            S_TBIAS: begin
                alu_a = r_t;
                alu_b = t_bias;
            end
            S_UMUL: begin
                alu_op = sbd_pkg::ALU_MUL;
                alu_a  = r_u;
                alu_b  = $signed({{(DW-10){1'b0}}, sbd_pkg::TURN_NUM});
            end
            S_TGAIN: begin
                alu_op = sbd_pkg::ALU_MUL;
                alu_a  = r_t;
                alu_b  = $signed({{(DW-sbd_pkg::GAIN_W){1'b0}}, r_gain});
            end
            S_UGAIN: begin
                alu_op = sbd_pkg::ALU_MUL;
                alu_a  = {{(DW-12){u_signed[11]}}, u_signed};
                alu_b  = $signed({{(DW-sbd_pkg::GAIN_W){1'b0}}, r_gain});
            end
            S_LEFT: begin
                alu_op = t_pos ? sbd_pkg::ALU_ADD : sbd_pkg::ALU_SUB;
                alu_a  = r_t;
                alu_b  = r_u;
            end
            S_RIGHT: begin
                alu_op = t_pos ? sbd_pkg::ALU_SUB : sbd_pkg::ALU_ADD;
                alu_a  = r_t;
                alu_b  = r_u;
            end
            default: begin
                alu_op = sbd_pkg::ALU_ADD;
            end
        endcase
    end

    sbd_alu #(
        .RCP_SHIFT (RCP_SHIFT)
    ) u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= sbd_pkg::GAIN_W'(1);
            r_lim_low  <= LIM_W'(600);
            r_lim_mid  <= LIM_W'(1200);
            r_lim_high <= LIM_W'(2100);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sbd_pkg::REG_DRIVE_GAIN: r_gain     <= i_cfg_data[sbd_pkg::GAIN_W-1:0];
                sbd_pkg::REG_LIMIT_LOW:  r_lim_low  <= i_cfg_data;
                sbd_pkg::REG_LIMIT_MID:  r_lim_mid  <= i_cfg_data;
                sbd_pkg::REG_LIMIT_HIGH: r_lim_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame byte store, written only while receiving
    always_ff @(posedge i_clk) begin
        if (in_acc && !i_s_tuser && r_pos >= sbd_pkg::FB_FIRST
                && r_pos <= sbd_pkg::FB_LAST) begin
            r_fb[fb_idx] <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= '0;
            r_hdr_good <= 1'b0;
            r_cnt      <= '0;
            r_tsum     <= '0;
            r_usum     <= '0;
            r_tbase    <= '0;
            r_ubase    <= '0;
            r_gear     <= sbd_pkg::GEAR_LOW;
            r_m_valid  <= 1'b0;
        end else begin
            // S_PUSH handles the output register itself
            if (r_m_valid && i_m_tready && r_state != S_PUSH) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_s_tuser) begin
                            r_hdr_good <= (i_s_tdata == sbd_pkg::SBUS_HEADER);
                            r_pos      <= POS_W'(1);
                        end else if (r_pos == '0 || r_pos > POS_LASTB) begin
                            r_pos <= '0;
                        end else if (r_pos < POS_LASTB) begin
                            r_pos <= r_pos + POS_W'(1);
                        end else begin
                            r_pos <= '0;
                            if (r_hdr_good && foot_ok) begin
                                r_gear  <= n_gear;
                                r_state <= (r_cnt < CALIB_N) ? S_CSUM_T : S_DT;
                            end
                        end
                    end
                end
                S_CSUM_T: begin
                    r_tsum  <= alu_y[SUM_W-1:0];
                    r_cnt   <= r_cnt + CNT_W'(1);
                    r_state <= S_CSUM_U;
                end
                S_CSUM_U: begin
                    r_usum <= alu_y[SUM_W-1:0];
                    r_l    <= '0;
                    r_r    <= '0;
                    if (r_cnt == CALIB_N) begin
                        r_state <= S_TBASE;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_TBASE: begin
                    r_tbase <= alu_y[CH_W-1:0];
                    r_state <= S_UBASE;
                end
                S_UBASE: begin
                    r_ubase <= alu_y[CH_W-1:0];
                    r_state <= S_PUSH;
                end
                S_DT: begin
                    r_t     <= alu_y;
                    r_state <= S_DR;
                end
                S_DR: begin
                    r_u <= alu_y;
                    if (r_t > -DW'(sbd_pkg::DEADBAND) && r_t < DW'(sbd_pkg::DEADBAND)) begin
                        r_t <= '0;
                    end
                    r_state <= S_TBIAS;
                end
                S_TBIAS: begin
                    r_t     <= alu_y;
                    r_usign <= r_u[DW-1];
                    if (r_u > -DW'(sbd_pkg::DEADBAND) && r_u < DW'(sbd_pkg::DEADBAND)) begin
                        r_u <= '0;
                    end else begin
                        r_u <= r_u[DW-1] ? -r_u : r_u;
                    end
                    r_state <= S_UMUL;
                end
                S_UMUL: begin
                    r_u     <= alu_y >>> sbd_pkg::TURN_SHIFT;
                    r_t     <= t_shift;
                    r_state <= S_TGAIN;
                end
                S_TGAIN: begin
                    r_t     <= alu_y;
                    r_state <= S_UGAIN;
                end
                S_UGAIN: begin
                    r_u     <= alu_y;
                    r_state <= S_LEFT;
                end
                S_LEFT: begin
                    r_l     <= alu_y;
                    r_state <= S_RIGHT;
                end
                S_RIGHT: begin
                    r_r     <= alu_y;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {3'b000, (r_cnt == CALIB_N), r_gear,
                                      cl_r[SPD_W-1:0], cl_l[SPD_W-1:0]};
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/sbd_alu.sv -----
module sbd_alu #(
    parameter int RCP_SHIFT = sbd_pkg::CH_W + 2 * $clog2(sbd_pkg::CALIB_FRAMES)
) (
    input  sbd_pkg::t_alu_op                  i_op,
    input  logic signed [sbd_pkg::DW-1:0]     i_a,
    input  logic signed [sbd_pkg::DW-1:0]     i_b,
    output logic signed [sbd_pkg::DW-1:0]     o_y
);

    localparam int RCP_W = 16;

    logic signed [sbd_pkg::DW-1:0] mul_a;
    logic signed [sbd_pkg::DW-1:0] mul_b;
    logic [2*RCP_W-1:0]            rcp_prod;
    logic [2*RCP_W-1:0]            rcp_shr;

    // multiply: 12-bit signed a by 10-bit unsigned b
    assign mul_a = {{(sbd_pkg::DW-12){i_a[11]}}, i_a[11:0]};
    assign mul_b = {{(sbd_pkg::DW-10){1'b0}}, i_b[9:0]};

    // reciprocal multiply: unsigned 16 by 16, upper part kept as the quotient
    assign rcp_prod = {{RCP_W{1'b0}}, i_a[RCP_W-1:0]} * {{RCP_W{1'b0}}, i_b[RCP_W-1:0]};
    assign rcp_shr  = rcp_prod >> RCP_SHIFT;

    always_comb begin
        case (i_op)
            sbd_pkg::ALU_ADD: o_y = i_a + i_b;
            sbd_pkg::ALU_SUB: o_y = i_a - i_b;
            sbd_pkg::ALU_MUL: o_y = mul_a * mul_b;
            sbd_pkg::ALU_RCP: o_y = rcp_shr[sbd_pkg::DW-1:0];
            default:          o_y = '0;
        endcase
    end

endmodule
